@@ design/min_priority_queue_unit_assert.svh @@
// Assertion macros shared by the priority queue checker.
// No dependencies; include by bare file name.
`ifndef MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Clocked implication or property, disabled during reset
`define MPQ_ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression that must never be true, disabled during reset
`define MPQ_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ design/mpq_pkg.sv @@
// Types and codes for the min priority queue unit.
// No dependencies; imported by every module of the block.
package mpq_pkg;

   // operation codes; code three is a no-op
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic signed [31:0] min_value;
      logic               min_valid;
      logic [4:0]         entry_count;
      logic [1:0]         status;
   } rsp_type;

   // operation broadcast to every cell of the chain
   typedef struct packed {
      logic               insert;
      logic               delete;
      logic signed [31:0] value;
   } cell_ctrl_type;

endpackage

@@ design/mpq_cell.sv @@
// One cell of the sorted chain: holds one entry, trades with its neighbors.
// Depends on mpq_pkg.
module mpq_cell import mpq_pkg::*; (
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic signed [31:0] left_value,
   input  logic               left_greater,
   input  logic               left_occupied,
   input  logic signed [31:0] right_value,
   input  logic               own_occupied,
   output logic signed [31:0] value,
   output logic               greater
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   // entry larger than the value being inserted
   assign greater = own_occupied && (value_ff > ctrl.value);
   assign value   = value_ff;

   // insert: shift up where the left neighbor is larger, else take the new value
   // at the slot where it belongs; delete: shift down from the right
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (left_occupied && left_greater) begin
            value_in = left_value;
         end else if (left_occupied && (!own_occupied || greater)) begin
            value_in = ctrl.value;
         end
      end else if (ctrl.delete) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ design/min_priority_queue_unit.sv @@
// Ascending priority queue of signed 32-bit values, built as a sorted cell chain.
// Depends on mpq_pkg and mpq_cell.
//
// Usage:
//   A request (req_data: mode, value) is taken at a rising edge with start high
//   and busy low. Modes: insert, delete minimum, clear; code three reports state.
//   busy stays low, so a request may be issued in every cycle.
//   Each request gives one result on rsp_data, shown with rsp_strobe for exactly
//   one cycle, the cycle after the request was taken, at one request per cycle.
//   The receiver cannot stall: a result must be taken when strobed. This rate
//   is set by the cell chain: every cell compares its entry with the new value
//   and swaps with a neighbor in the same edge, so the head cell always holds
//   the minimum.
//   Results: removed value, minimum after the operation with a valid flag,
//   entry count (low 5 bits) and status (ok, delete on empty, insert on full).
//   A refused request changes nothing.
//   Reset (synchronous) empties the queue and drops any pending strobe; no
//   clearing pass is needed since only occupied cells are ever read.
module min_priority_queue_unit import mpq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int OW = $clog2(CAPACITY + 1);

   logic [OW-1:0]      occupancy_ff;
   logic [OW-1:0]      occupancy_in;
   logic               rsp_strobe_ff;
   logic signed [31:0] removed_ff;
   logic signed [31:0] removed_in;
   logic [1:0]         status_ff;
   logic [1:0]         status_in;
   logic               accept;
   logic               full;
   logic               empty;
   cell_ctrl_type      ctrl;

   logic signed [31:0] cell_value   [CAPACITY];
   logic               cell_greater [CAPACITY];
   logic               occupied     [CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (occupancy_ff == OW'(CAPACITY));
   assign empty  = (occupancy_ff == '0);

   // decode the request
   always_comb begin
      occupancy_in = occupancy_ff;
      removed_in   = '0;
      status_in    = STATUS_OK;
      ctrl.insert  = 1'b0;
      ctrl.delete  = 1'b0;
      ctrl.value   = req_data.value;
      if (accept) begin
         unique case (req_data.mode)
            MODE_INSERT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  ctrl.insert  = 1'b1;
                  occupancy_in = occupancy_ff + OW'(1);
               end
            end
            MODE_DELETE: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  ctrl.delete  = 1'b1;
                  removed_in   = cell_value[0];
                  occupancy_in = occupancy_ff - OW'(1);
               end
            end
            MODE_CLEAR: begin
               occupancy_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // the sorted chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = (occupancy_ff > OW'(i));
      if (i == 0) begin : g_head
         mpq_cell u_cell (
            .clock         (clock),
            .ctrl          (ctrl),
            .left_value    ('0),
            .left_greater  (1'b0),
            .left_occupied (1'b1),
            .right_value   (cell_value[(i + 1) % CAPACITY]),
            .own_occupied  (occupied[i]),
            .value         (cell_value[i]),
            .greater       (cell_greater[i])
         );
      end else begin : g_body
         mpq_cell u_cell (
            .clock         (clock),
            .ctrl          (ctrl),
            .left_value    (cell_value[i - 1]),
            .left_greater  (cell_greater[i - 1]),
            .left_occupied (occupied[i - 1]),
            .right_value   (cell_value[(i + 1) % CAPACITY]),
            .own_occupied  (occupied[i]),
            .value         (cell_value[i]),
            .greater       (cell_greater[i])
         );
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         occupancy_ff  <= occupancy_in;
         rsp_strobe_ff <= accept;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   // result from state after the operation
   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_data.removed_value = removed_ff;
   assign rsp_data.min_value     = empty ? 32'sd0 : cell_value[0];
   assign rsp_data.min_valid     = !empty;
   assign rsp_data.entry_count   = 5'(occupancy_ff);
   assign rsp_data.status        = status_ff;

endmodule

@@ design/mpq_checker.sv @@
// Port-level checks for min_priority_queue_unit, with its bind statement.
// Depends on mpq_pkg and min_priority_queue_unit_assert.svh.
`include "min_priority_queue_unit_assert.svh"

module mpq_port_checker import mpq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // one result per request, in the cycle after it
   `MPQ_ASSERT_PROP(a_strobe_follows, clock, reset, rsp_strobe == $past(start && !busy && !reset), "result strobe does not match request")

   // an empty queue reports a zero minimum
   `MPQ_ASSERT_PROP(a_empty_min, clock, reset, rsp_strobe && !rsp_data.min_valid |-> rsp_data.min_value == 32'sd0 && rsp_data.entry_count == 5'd0, "empty queue shows a minimum")

   // refused delete only happens on an empty queue and removes nothing
   `MPQ_ASSERT_PROP(a_refused_delete, clock, reset, rsp_strobe && rsp_data.status == STATUS_EMPTY |-> !rsp_data.min_valid && rsp_data.removed_value == 32'sd0, "bad refused delete")

   // after a delete the new minimum is never below the removed one
   `MPQ_ASSERT_PROP(a_delete_order, clock, reset, rsp_strobe && $past(req_data.mode) == MODE_DELETE && rsp_data.status == STATUS_OK && rsp_data.min_valid |-> rsp_data.min_value >= rsp_data.removed_value, "queue order broken by delete")

   // a refused insert leaves the queue holding entries
   `MPQ_ASSERT_NEVER(a_full_empty, clock, reset, rsp_strobe && rsp_data.status == STATUS_FULL && !rsp_data.min_valid, "full queue reported empty")

endmodule

bind min_priority_queue_unit mpq_port_checker u_mpq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

@@ tb/mpq_checker.sv @@
// Result checker for the min priority queue unit: predicts every response and compares it.
// Depends on mpq_pkg; watches the request and response channels of the block.
module mpq_checker import mpq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 100;

   // ascending copy of the queue contents
   logic signed [31:0] sorted_entries [CAPACITY];
   int                 held_count;

   rsp_type awaited_rsp_q [$];
   rsp_type oldest_rsp;
   int      error_total;
   int      pending_count;

   assign fail_count = error_total;
   assign pending    = pending_count;

   initial begin
      error_total   = 0;
      held_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_total < PRINT_LIMIT) begin
         $display("%0t mpq_checker: %s got %0h, expected %0h", $time, field, got, want);
      end
      error_total++;
   endtask

   // apply one request to the queue copy and build the response it causes
   function automatic rsp_type apply_request(input req_type r);
      rsp_type res;
      int      pos;
      res        = '0;
      res.status = STATUS_OK;
      unique case (r.mode)
         MODE_INSERT: begin
            if (held_count >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               // larger entries move up; equal values stay ahead of the new one
               pos = held_count;
               while (pos > 0 && sorted_entries[pos-1] > r.value) begin
                  sorted_entries[pos] = sorted_entries[pos-1];
                  pos--;
               end
               sorted_entries[pos] = r.value;
               held_count++;
            end
         end
         MODE_DELETE: begin
            if (held_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.removed_value = sorted_entries[0];
               for (int i = 1; i < held_count; i++) begin
                  sorted_entries[i-1] = sorted_entries[i];
               end
               held_count--;
            end
         end
         MODE_CLEAR: begin
            held_count = 0;
         end
         default: begin
            // code three leaves everything as it is
         end
      endcase
      res.min_valid   = (held_count > 0);
      res.min_value   = (held_count > 0) ? sorted_entries[0] : '0;
      res.entry_count = 5'(held_count);
      return res;
   endfunction

   // predict on every accepted request, compare on every strobe
   always @(posedge clock) begin
      if (reset) begin
         awaited_rsp_q.delete();
         held_count = 0;
      end else begin
         if (start && !busy) begin
            awaited_rsp_q.push_back(apply_request(req_data));
         end
         if (rsp_strobe) begin
            if (awaited_rsp_q.size() == 0) begin
               report_mismatch("response with no request pending", rsp_data.min_value, '0);
            end else begin
               oldest_rsp = awaited_rsp_q.pop_front();
               if (rsp_data.removed_value !== oldest_rsp.removed_value)
                  report_mismatch("removed_value", rsp_data.removed_value,
                                  oldest_rsp.removed_value);
               if (rsp_data.min_value !== oldest_rsp.min_value)
                  report_mismatch("min_value", rsp_data.min_value, oldest_rsp.min_value);
               if (rsp_data.min_valid !== oldest_rsp.min_valid)
                  report_mismatch("min_valid", rsp_data.min_valid, oldest_rsp.min_valid);
               if (rsp_data.entry_count !== oldest_rsp.entry_count)
                  report_mismatch("entry_count", rsp_data.entry_count,
                                  oldest_rsp.entry_count);
               if (rsp_data.status !== oldest_rsp.status)
                  report_mismatch("status", rsp_data.status, oldest_rsp.status);
            end
         end
      end
      pending_count = awaited_rsp_q.size();
   end

endmodule

@@ tb/tb_top.sv @@
// Top of the min priority queue testbench: clock, reset, request stimulus and verdict.
// Depends on mpq_pkg, min_priority_queue_unit and mpq_checker.
module tb_top;
   import mpq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = 16;
   localparam int PHASES       = 11;
   localparam int PHASE_ITEMS  = 150;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   logic    idle_gaps = 1'b1;

   always #4 clock = ~clock;

   min_priority_queue_unit #(.CAPACITY(CAPACITY)) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   mpq_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // issue one request after an optional idle gap; returns once it is taken
   task automatic issue_request(input logic [1:0] mode, input logic signed [31:0] value);
      int gap;
      gap = idle_gaps ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_data.mode  <= mode;
      req_data.value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // value mixes: full range, a narrow band that makes duplicates, extremes
   function automatic logic signed [31:0] draw_value(input int kind);
      logic signed [31:0] v;
      case (kind)
         0: v = $urandom;
         1: v = $signed($urandom_range(0, 7)) - 4;
         default: begin
            case ($urandom_range(0, 4))
               0: v = VALUE_MAX;
               1: v = VALUE_MIN;
               2: v = '0;
               3: v = -1;
               default: v = $urandom;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic logic [1:0] draw_mode(input int insert_pct);
      int roll;
      logic [1:0] m;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) m = MODE_INSERT;
      else if (roll < 97) m = MODE_DELETE;
      else if (roll < 99) m = MODE_CLEAR;
      else m = MODE_NOP;
      return m;
   endfunction

   initial begin
      int insert_mix [5];
      insert_mix = '{80, 20, 50, 65, 35};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue cases, extremes, duplicates, no-op code
      issue_request(MODE_DELETE, 32'sd5);
      issue_request(MODE_NOP, 32'sd9);
      issue_request(MODE_INSERT, VALUE_MAX);
      issue_request(MODE_INSERT, VALUE_MIN);
      issue_request(MODE_INSERT, 32'sd0);
      issue_request(MODE_INSERT, -32'sd1);
      issue_request(MODE_INSERT, -32'sd1);
      issue_request(MODE_DELETE, 32'sd0);
      issue_request(MODE_DELETE, 32'sd0);
      issue_request(MODE_NOP, VALUE_MIN);
      issue_request(MODE_CLEAR, VALUE_MAX);
      issue_request(MODE_DELETE, 32'sd0);

      // directed: fill to capacity, then insert on a full queue
      for (int i = 0; i < CAPACITY; i++) begin
         issue_request(MODE_INSERT, $urandom);
      end
      issue_request(MODE_INSERT, VALUE_MIN);
      issue_request(MODE_CLEAR, 32'sd0);

      // random phases with varying insert bias, value mix and idle pattern
      for (int p = 0; p < PHASES; p++) begin
         idle_gaps = (p % 4 != 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            issue_request(draw_mode(insert_mix[p % 5]), draw_value(p % 3));
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #3_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
